// ===== rtl/core/hcbr_pkg.sv =====
// Shared types, constants and tables for the hash counter bounded generator.
`default_nettype none
package hcbr_pkg;

	localparam int SEED_W = 96;
	localparam int QW     = 33;

	typedef struct packed {
		logic        req_type;
		logic [30:0] range_size;
		logic [7:0]  generator_index;
		logic        use_display;
	} req_t;

	typedef struct packed {
		logic [30:0] value;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EMPTY     = 2'd1,
		STATUS_RESERVED  = 2'd2,
		STATUS_OUT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		REQ_DRAW   = 1'b0,
		REQ_RESEED = 1'b1
	} req_kind_t;

	typedef enum logic {
		REG_SEED_LOW  = 1'b0,
		REG_SEED_HIGH = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_QDIV,
		ST_MUL,
		ST_HASH,
		ST_HWAIT,
		ST_SCAN,
		ST_VDIV,
		ST_OUT
	} state_t;

	typedef logic [7:0][31:0] digest_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

// ===== rtl/core/hcbr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module hcbr_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [hcbr_pkg::QW-1:0] dividend,
	input  wire logic [hcbr_pkg::QW-1:0] divisor,
	output logic                       done,
	output logic [hcbr_pkg::QW-1:0]    quotient
);

	localparam int QW = hcbr_pkg::QW;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [QW:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [QW-1:0] div_q;
	logic [QW:0]   trial;
	logic          fits;

	assign trial = {rem_q[QW-1:0], quo_q[QW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, div_q} : trial;
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/hcbr_sha.sv =====
// Iterative SHA-256 core for one padded block holding a 12-byte seed.
`default_nettype none
module hcbr_sha (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [hcbr_pkg::SEED_W-1:0] seed,
	output logic                             done,
	output hcbr_pkg::digest_t                digest
);

	logic               busy_q;
	logic               done_q;
	logic [5:0]         rnd_q;
	logic [7:0][31:0]   v_q;
	logic [15:0][31:0]  w_q;
	logic [31:0]        s0, s1, ch, mj, t0, t1, g0, g1, w_new;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	always_comb begin
		s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
		t0 = v_q[7] + s1 + ch + hcbr_pkg::ROUND_K[rnd_q] + w_q[0];
		s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj = ((v_q[0] | v_q[1]) & v_q[2]) | (v_q[0] & v_q[1]);
		t1 = s0 + mj;
		g0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		g1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = g1 + w_q[9] + g0 + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hcbr_pkg::INIT_H[i];
			end
			w_q <= {32'd96, {11{32'd0}}, 32'h8000_0000, bswap(seed[95:64]),
				bswap(seed[63:32]), bswap(seed[31:0])};
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t0;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t0 + t1;
			w_q    <= {w_new, w_q[15:1]};
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[i] = hcbr_pkg::INIT_H[i] + v_q[i];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/hash_counter_bounded_rng.sv =====
// Top level: seed bank, draw sequencer, configuration port and result register.
//
// Channels: req (req_valid, req_stall, req) carries one request transaction;
// rsp (rsp_valid, rsp_stall, rsp) returns exactly one result per request.
// A transaction moves on a clock edge with valid high and stall low.
// Reseed and error requests skip the hash and go straight to the output
// state. A draw runs the bound divide, SHA-256 passes (64 rounds in one
// shared round unit, each pass with a scan of up to 8 digest words) and
// the final divide; a pass with no word in range is rejected and the next
// seed hashed. Both divides share one divider. req_stall is high while a
// request is in work; one request at a time. The result sits in an output
// register; when rsp_stall holds it, the next finished result waits in the
// sequencer until the register frees. Reset clears the seed registers, all
// slot seeds and the display seed at once: per-slot valid bits mark
// entries written since the last reseed, others read as the reseed
// pattern (or zero before any reseed). Configuration must be written
// over the APB port only while the block is idle, which it does not check.
`default_nettype none
module hash_counter_bounded_rng #(
	parameter int NUM_GENERATORS = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire hcbr_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output hcbr_pkg::rsp_t      rsp,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [63:0]    pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	localparam int IW     = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
	localparam int SEED_W = hcbr_pkg::SEED_W;
	localparam int QW     = hcbr_pkg::QW;

	hcbr_pkg::state_t state_q, state_d;

	logic [63:0]        seed_low_q;
	logic [31:0]        seed_high_q;
	logic [SEED_W-1:0]  base_q;
	logic               reseeded_q;
	logic [NUM_GENERATORS-1:0] valid_q;
	logic [SEED_W-1:0]  mem [NUM_GENERATORS];
	logic [SEED_W-1:0]  mem_rd_q;
	logic [SEED_W-1:0]  display_q;

	hcbr_pkg::req_t     req_q;
	logic [SEED_W-1:0]  seed_q;
	logic [QW-1:0]      q_q;
	logic [QW-1:0]      limit_q;
	hcbr_pkg::digest_t  dig_q;
	logic [2:0]         scan_q;
	hcbr_pkg::rsp_t     res_q;
	hcbr_pkg::rsp_t     out_q;
	logic               out_valid_q;

	logic               accept;
	logic               cfg_wr;
	logic               div_start, div_done, sha_start, sha_done;
	logic [QW-1:0]      div_dividend, div_divisor, div_quo;
	hcbr_pkg::digest_t  sha_dig;
	logic [QW-1:0]      prod;
	logic               hit;
	logic               out_load;
	logic               wb;
	logic [IW-1:0]      addr;
	logic [7:0]         top_byte;
	logic [SEED_W-1:0]  slot_seed;

	assign accept    = req_valid && !req_stall;
	assign req_stall = state_q != hcbr_pkg::ST_IDLE;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign addr      = req_q.generator_index[IW-1:0];
	// q * range never exceeds 2^32, so the low QW bits are exact
	assign prod      = q_q * {2'b0, req_q.range_size};
	assign hit       = {1'b0, dig_q[scan_q]} < limit_q;
	assign top_byte  = base_q[95:88] + req_q.generator_index;

	always_comb begin
		case (hcbr_pkg::reg_idx_t'(paddr[3]))
			hcbr_pkg::REG_SEED_LOW:  prdata = seed_low_q;
			hcbr_pkg::REG_SEED_HIGH: prdata = {32'b0, seed_high_q};
			default:                 prdata = '0;
		endcase
	end

	always_comb begin
		if (valid_q[addr]) begin
			slot_seed = mem_rd_q;
		end else if (reseeded_q) begin
			slot_seed = {top_byte, base_q[87:0]};
		end else begin
			slot_seed = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hcbr_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == hcbr_pkg::REQ_RESEED || req.range_size == '0) begin
						state_d = hcbr_pkg::ST_OUT;
					end else if (req.use_display) begin
						state_d = hcbr_pkg::ST_LOAD;
					end else if (req.generator_index == '0 ||
							32'(req.generator_index) >= NUM_GENERATORS) begin
						state_d = hcbr_pkg::ST_OUT;
					end else begin
						state_d = hcbr_pkg::ST_LOAD;
					end
				end
			end
			hcbr_pkg::ST_LOAD:  state_d = hcbr_pkg::ST_QDIV;
			hcbr_pkg::ST_QDIV:  if (div_done) state_d = hcbr_pkg::ST_MUL;
			hcbr_pkg::ST_MUL:   state_d = hcbr_pkg::ST_HASH;
			hcbr_pkg::ST_HASH:  state_d = hcbr_pkg::ST_HWAIT;
			hcbr_pkg::ST_HWAIT: if (sha_done) state_d = hcbr_pkg::ST_SCAN;
			hcbr_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = hcbr_pkg::ST_VDIV;
				end else if (scan_q == 3'd7) begin
					state_d = hcbr_pkg::ST_HASH;
				end
			end
			hcbr_pkg::ST_VDIV:  if (div_done) state_d = hcbr_pkg::ST_OUT;
			hcbr_pkg::ST_OUT:   if (!out_valid_q || !rsp_stall) state_d = hcbr_pkg::ST_IDLE;
			default:            state_d = hcbr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = {1'b1, 32'b0};
		div_divisor  = {2'b0, req_q.range_size};
		sha_start    = 1'b0;
		wb           = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			hcbr_pkg::ST_LOAD: div_start = 1'b1;
			hcbr_pkg::ST_HASH: sha_start = 1'b1;
			hcbr_pkg::ST_SCAN: begin
				div_start    = hit;
				div_dividend = {1'b0, dig_q[scan_q]};
				div_divisor  = q_q;
			end
			hcbr_pkg::ST_VDIV: wb = div_done;
			hcbr_pkg::ST_OUT:  out_load = !out_valid_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hcbr_pkg::ST_IDLE;
			seed_low_q  <= '0;
			seed_high_q <= '0;
			reseeded_q  <= 1'b0;
			valid_q     <= '0;
			display_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (hcbr_pkg::reg_idx_t'(paddr[3]))
					hcbr_pkg::REG_SEED_LOW:  seed_low_q  <= pwdata;
					hcbr_pkg::REG_SEED_HIGH: seed_high_q <= pwdata[31:0];
					default: begin
					end
				endcase
			end
			if (accept && req.req_type == hcbr_pkg::REQ_RESEED) begin
				reseeded_q <= 1'b1;
				valid_q    <= '0;
			end
			if (wb) begin
				if (req_q.use_display) begin
					display_q <= seed_q;
				end else begin
					valid_q[addr] <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem[req.generator_index[IW-1:0]];
		if (wb && !req_q.use_display) begin
			mem[addr] <= seed_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= req;
			res_q.value <= '0;
			if (req.req_type == hcbr_pkg::REQ_RESEED) begin
				base_q       <= {seed_high_q, seed_low_q};
				res_q.status <= hcbr_pkg::STATUS_OK;
			end else if (req.range_size == '0) begin
				res_q.status <= hcbr_pkg::STATUS_EMPTY;
			end else if (!req.use_display && req.generator_index == '0) begin
				res_q.status <= hcbr_pkg::STATUS_RESERVED;
			end else if (!req.use_display && 32'(req.generator_index) >= NUM_GENERATORS) begin
				res_q.status <= hcbr_pkg::STATUS_OUT_RANGE;
			end else begin
				res_q.status <= hcbr_pkg::STATUS_OK;
			end
		end
		case (state_q)
			hcbr_pkg::ST_LOAD:  seed_q <= req_q.use_display ? display_q : slot_seed;
			hcbr_pkg::ST_QDIV:  if (div_done) q_q <= div_quo;
			hcbr_pkg::ST_MUL:   limit_q <= prod;
			hcbr_pkg::ST_HWAIT: begin
				if (sha_done) begin
					dig_q  <= sha_dig;
					seed_q <= seed_q + 96'd1;
					scan_q <= '0;
				end
			end
			hcbr_pkg::ST_SCAN:  scan_q <= scan_q + 3'd1;
			hcbr_pkg::ST_VDIV:  if (div_done) res_q.value <= div_quo[30:0];
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	hcbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	hcbr_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.seed   (seed_q),
		.done   (sha_done),
		.digest (sha_dig)
	);

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire
